// ----- rtl/strongly_connected_component_count_assert.svh -----
// assertion macros for the scc counter rtl
// no dependencies; expects clk and arst_n in the including module
`ifndef STRONGLY_CONNECTED_COMPONENT_COUNT_ASSERT_SVH
`define STRONGLY_CONNECTED_COMPONENT_COUNT_ASSERT_SVH

// condition that holds at every edge out of reset
`define SCC_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define SCC_IMPLY(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

`endif

// ----- rtl/scc_pkg.sv -----
// shared constants and types for the scc counter
// no dependencies
package scc_pkg;

	localparam int MAX_NODES_DEF = 64;
	localparam int CFG_W         = 7;
	localparam int FIELD_W       = 6;
	localparam int CHUNK_W       = 8;
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 7'd64;

	localparam logic CMD_EDGE = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	typedef struct packed {
		logic done;
		logic found;
	} scan_t;

endpackage

// ----- rtl/scc_ram.sv -----
// generic simple dual port ram with registered read
// no dependencies
module scc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/scc_scan.sv -----
// find-first-set unit, one chunk of the row per cycle
// depends on scc_pkg
module scc_scan #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [MAX_NODES-1:0]         word,
	output scc_pkg::scan_t               res,
	output logic [$clog2(MAX_NODES)-1:0] idx
);
	import scc_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int NCH = (MAX_NODES + CHUNK_W - 1) / CHUNK_W;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int CBW = $clog2(CHUNK_W);

	logic [NCH*CHUNK_W-1:0] padded_w;
	logic [CHUNK_W-1:0]     chunk_w;
	logic [CBW-1:0]         pos_w;
	logic                   last_w;
	logic                   busy_q;
	logic [CW-1:0]          chunk_q;
	scan_t                  res_q;
	logic [NW-1:0]          idx_q;

	always_comb begin
		padded_w = '0;
		padded_w[MAX_NODES-1:0] = word;
	end

	assign chunk_w = padded_w[chunk_q*CHUNK_W +: CHUNK_W];
	assign last_w  = (chunk_q == CW'(NCH - 1));

	// lowest set bit of the chunk
	always_comb begin
		pos_w = '0;
		for (int b = CHUNK_W - 1; b >= 0; b--) begin
			if (chunk_w[b]) begin
				pos_w = CBW'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
			res_q   <= '0;
		end else begin
			if (start) begin
				busy_q     <= 1'b1;
				chunk_q    <= '0;
				res_q.done <= 1'b0;
			end else if (busy_q && ((|chunk_w) || last_w)) begin
				busy_q      <= 1'b0;
				res_q.done  <= 1'b1;
				res_q.found <= |chunk_w;
			end else begin
				res_q.done <= 1'b0;
				if (busy_q) begin
					chunk_q <= chunk_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			idx_q <= NW'({chunk_q, pos_w});
		end
	end

	assign res = res_q;
	assign idx = idx_q;

endmodule

// ----- rtl/strongly_connected_component_count.sv -----
// strongly connected component counter, kosaraju method, one shared scan unit
// edge item: row read, then row write; run item: forward walk, reverse walk, then the result
//   waits out any output stall
// throughput: one item at a time, in_stall is high until the current item is done
// reset: graph rows empty (row valid bits cleared), node_count 64, no result pending
// depends on scc_pkg, scc_ram, scc_scan, strongly_connected_component_count_assert.svh
module strongly_connected_component_count #(
	parameter int MAX_NODES = scc_pkg::MAX_NODES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [scc_pkg::CFG_W-1:0]   node_count,
	// input items
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        command,
	input  logic [scc_pkg::FIELD_W-1:0] edge_from,
	input  logic [scc_pkg::FIELD_W-1:0] edge_to,
	// result items
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [scc_pkg::CFG_W-1:0]   component_count
);
	import scc_pkg::*;

	`include "strongly_connected_component_count_assert.svh"

	localparam int NW    = $clog2(MAX_NODES);
	localparam int CNT_W = NW + 1;

	typedef enum logic [10:0] {
		ST_IDLE      = 11'b000_0000_0001,
		ST_EDGE      = 11'b000_0000_0010,
		ST_INIT      = 11'b000_0000_0100,
		ST_OUTER1    = 11'b000_0000_1000,
		ST_OUTER2    = 11'b000_0001_0000,
		ST_FIN_RD    = 11'b000_0010_0000,
		ST_ROW_RD    = 11'b000_0100_0000,
		ST_ROW_LATCH = 11'b000_1000_0000,
		ST_SCAN      = 11'b001_0000_0000,
		ST_POP_RD    = 11'b010_0000_0000,
		ST_OUT       = 11'b100_0000_0000
	} state_t;

	state_t               state_q;
	logic [CFG_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n_q;
	logic [MAX_NODES-1:0] active_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] fvalid_q;       // forward row holds written data
	logic [MAX_NODES-1:0] rvalid_q;       // reverse row holds written data
	logic [MAX_NODES-1:0] row_q;          // candidate successors of the top node
	logic                 pass_q;         // 0 forward walk, 1 reverse walk
	logic [NW-1:0]        top_q;
	logic [NW-1:0]        sp_q;           // entries under the top in the walk stack
	logic [CNT_W-1:0]     i_q;
	logic [CNT_W-1:0]     done_q;         // finish order length
	logic [CNT_W-1:0]     pos_q;
	logic [CFG_W-1:0]     tally_q;
	logic [NW-1:0]        a_q;
	logic [NW-1:0]        b_q;
	logic                 edge_ok_q;

	// ram ports
	logic [MAX_NODES-1:0] f_rdata, r_rdata, f_wdata, r_wdata;
	logic [NW-1:0]        f_raddr, r_raddr;
	logic                 row_we;
	logic [NW-1:0]        fin_rdata, stk_rdata, fin_raddr, stk_raddr;
	logic                 fin_we, stk_we;
	logic [CNT_W-1:0]     pos_m1_w;

	// scan unit
	scan_t                scan_res;
	logic [NW-1:0]        scan_idx;
	logic                 scan_start;

	// visited set request
	logic                 vis_set;
	logic [NW-1:0]        vis_idx;
	logic [CNT_W-1:0]     n_clamp_w;
	logic                 in_acc;
	logic                 edge_ok_w;

	assign cfg_ready       = 1'b1;
	assign in_stall        = (state_q != ST_IDLE);
	assign in_acc          = in_valid && !in_stall;
	assign out_valid       = (state_q == ST_OUT);
	assign component_count = tally_q;

	// nodes beyond the graph store are dropped on arrival
	assign edge_ok_w = (32'(edge_from) < MAX_NODES) && (32'(edge_to) < MAX_NODES);

	// node_count beyond the store counts as the whole store
	assign n_clamp_w = (32'(node_count_q) > MAX_NODES) ? CNT_W'(MAX_NODES)
	                                                  : CNT_W'(node_count_q);

	// row reads: edge endpoints when idle, otherwise the node on top of the walk
	assign f_raddr = (state_q == ST_IDLE) ? NW'(edge_from) : top_q;
	assign r_raddr = (state_q == ST_IDLE) ? NW'(edge_to) : top_q;

	// read-modify-write of both rows; an unwritten row reads as empty
	always_comb begin
		f_wdata = fvalid_q[a_q] ? f_rdata : '0;
		r_wdata = rvalid_q[b_q] ? r_rdata : '0;
		f_wdata[b_q] = 1'b1;
		r_wdata[a_q] = 1'b1;
	end
	assign row_we = (state_q == ST_EDGE) && edge_ok_q;

	assign pos_m1_w   = pos_q - CNT_W'(1);
	assign fin_raddr  = pos_m1_w[NW-1:0];
	assign stk_raddr  = sp_q - NW'(1);
	assign fin_we     = (state_q == ST_SCAN) && scan_res.done && !scan_res.found && !pass_q;
	assign stk_we     = (state_q == ST_SCAN) && scan_res.done && scan_res.found;
	assign scan_start = (state_q == ST_ROW_LATCH);

	scc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_fwd_ram (
		.clk(clk), .we(row_we), .waddr(a_q), .wdata(f_wdata),
		.raddr(f_raddr), .rdata(f_rdata)
	);

	scc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_rev_ram (
		.clk(clk), .we(row_we), .waddr(b_q), .wdata(r_wdata),
		.raddr(r_raddr), .rdata(r_rdata)
	);

	// finish order of the forward pass
	scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fin_ram (
		.clk(clk), .we(fin_we), .waddr(done_q[NW-1:0]), .wdata(top_q),
		.raddr(fin_raddr), .rdata(fin_rdata)
	);

	// depth-first walk stack, top node kept in top_q
	scc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stk_ram (
		.clk(clk), .we(stk_we), .waddr(sp_q), .wdata(top_q),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// every walk step re-reads one adjacency row and scans it 8 bits per cycle
	scc_scan #(.MAX_NODES(MAX_NODES)) u_scan (
		.clk(clk), .arst_n(arst_n), .start(scan_start), .word(row_q),
		.res(scan_res), .idx(scan_idx)
	);

	// which node gets marked visited this cycle
	always_comb begin
		vis_set = 1'b0;
		vis_idx = top_q;
		case (state_q)
			ST_OUTER1: begin
				vis_set = (i_q != n_q) && !visited_q[i_q[NW-1:0]];
				vis_idx = i_q[NW-1:0];
			end
			ST_FIN_RD: begin
				vis_set = !visited_q[fin_rdata];
				vis_idx = fin_rdata;
			end
			ST_SCAN: begin
				vis_set = scan_res.done && scan_res.found;
				vis_idx = scan_idx;
			end
			default: begin
				vis_set = 1'b0;
			end
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= NODE_COUNT_RST;
			fvalid_q     <= '0;
			rvalid_q     <= '0;
			visited_q    <= '0;
			active_q     <= '0;
			n_q          <= '0;
			pass_q       <= 1'b0;
			top_q        <= '0;
			sp_q         <= '0;
			i_q          <= '0;
			done_q       <= '0;
			pos_q        <= '0;
			tally_q      <= '0;
			edge_ok_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				node_count_q <= node_count;
			end
			if (vis_set) begin
				visited_q[vis_idx] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (command == CMD_RUN) begin
							state_q <= ST_INIT;
						end else begin
							edge_ok_q <= edge_ok_w;
							state_q   <= ST_EDGE;
						end
					end
				end
				ST_EDGE: begin
					if (edge_ok_q) begin
						fvalid_q[a_q] <= 1'b1;
						rvalid_q[b_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_INIT: begin
					n_q <= n_clamp_w;
					for (int j = 0; j < MAX_NODES; j++) begin
						active_q[j] <= (CNT_W'(j) < n_clamp_w);
					end
					visited_q <= '0;
					i_q       <= '0;
					done_q    <= '0;
					tally_q   <= '0;
					pass_q    <= 1'b0;
					state_q   <= ST_OUTER1;
				end
				ST_OUTER1: begin
					// forward pass: start a walk at every unvisited node in order
					if (i_q == n_q) begin
						visited_q <= '0;
						pos_q     <= done_q;
						pass_q    <= 1'b1;
						state_q   <= ST_OUTER2;
					end else begin
						i_q <= i_q + CNT_W'(1);
						if (!visited_q[i_q[NW-1:0]]) begin
							top_q   <= i_q[NW-1:0];
							sp_q    <= '0;
							state_q <= ST_ROW_RD;
						end
					end
				end
				ST_OUTER2: begin
					// reverse pass in reverse finish order
					if (pos_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						pos_q   <= pos_m1_w;
						state_q <= ST_FIN_RD;
					end
				end
				ST_FIN_RD: begin
					if (visited_q[fin_rdata]) begin
						state_q <= ST_OUTER2;
					end else begin
						top_q   <= fin_rdata;
						sp_q    <= '0;
						tally_q <= tally_q + CFG_W'(1);
						state_q <= ST_ROW_RD;
					end
				end
				ST_ROW_RD: begin
					state_q <= ST_ROW_LATCH;
				end
				ST_ROW_LATCH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						if (scan_res.found) begin
							// push the current node, descend into the successor
							sp_q    <= sp_q + NW'(1);
							top_q   <= scan_idx;
							state_q <= ST_ROW_RD;
						end else begin
							if (!pass_q) begin
								done_q <= done_q + CNT_W'(1);
							end
							if (sp_q == '0) begin
								state_q <= pass_q ? ST_OUTER2 : ST_OUTER1;
							end else begin
								sp_q    <= sp_q - NW'(1);
								state_q <= ST_POP_RD;
							end
						end
					end
				end
				ST_POP_RD: begin
					top_q   <= stk_rdata;
					state_q <= ST_ROW_RD;
				end
				ST_OUT: begin
					// result taken: the graph store is emptied at once
					if (!out_stall) begin
						fvalid_q <= '0;
						rvalid_q <= '0;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// row payload, masked to active unvisited nodes
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW_LATCH) begin
			if (pass_q) begin
				row_q <= (rvalid_q[top_q] ? r_rdata : '0) & ~visited_q & active_q;
			end else begin
				row_q <= (fvalid_q[top_q] ? f_rdata : '0) & ~visited_q & active_q;
			end
		end
		if (state_q == ST_IDLE) begin
			a_q <= NW'(edge_from);
			b_q <= NW'(edge_to);
		end
	end

	`SCC_IMPLY(a_stack_depth, state_q == ST_SCAN, CNT_W'(sp_q) < n_q, "walk stack deeper than node count")
	`SCC_ALWAYS(a_finish_bound, done_q <= n_q, "finish order longer than node count")
	`SCC_IMPLY(a_all_finished, state_q == ST_OUTER1 && i_q == n_q, done_q == n_q, "forward pass left nodes unfinished")
	`SCC_IMPLY(a_scan_target, scan_res.done && scan_res.found, !visited_q[scan_idx] && active_q[scan_idx], "scan returned a visited or inactive node")

endmodule

// ----- test/strongly_connected_component_count_tb.sv -----
// testbench for the scc counter: random graphs with edge and run items, checked
// against an in-bench kosaraju predictor; depends on scc_pkg and the rtl top

module strongly_connected_component_count_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scc_pkg::*;

	localparam int NODES = MAX_NODES_DEF;
	localparam int WATCHDOG_LIMIT = 200000;
	// settle time before a config write; drain waits one hundredth of it
	localparam int SETTLE_CYCLES = 80000;

	typedef struct packed {
		logic                command;
		logic [FIELD_W-1:0]  edge_from;
		logic [FIELD_W-1:0]  edge_to;
	} graph_item_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_W-1:0] node_count;
	logic in_valid;
	logic in_stall;
	logic command;
	logic [FIELD_W-1:0] edge_from;
	logic [FIELD_W-1:0] edge_to;
	logic out_valid;
	logic out_stall;
	logic [CFG_W-1:0] component_count;

	strongly_connected_component_count u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .node_count(node_count),
		.in_valid(in_valid), .in_stall(in_stall), .command(command),
		.edge_from(edge_from), .edge_to(edge_to),
		.out_valid(out_valid), .out_stall(out_stall),
		.component_count(component_count)
	);

	// predictor state: own copy of the graph and the register
	logic [NODES-1:0] fwd_rows [NODES] = '{default: '0};
	logic [NODES-1:0] rev_rows [NODES] = '{default: '0};
	logic [CFG_W-1:0] pred_node_count;

	graph_item_t      pending_items [$];
	logic [CFG_W-1:0] expected_counts [$];

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  failed = 1'b0;
	int  quiet_cycles = 0;
	bit  sender_hold;

	// stall as sampled at the last rising edge, so the driver knows what was taken
	logic in_stall_q;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// kosaraju on the predictor rows, clears the graph afterwards
	function automatic logic [CFG_W-1:0] count_components();
		int n, sp, done, top, nxt, tally;
		logic [NODES-1:0] active, visited, row;
		int order [NODES];
		int stack [NODES];
		n = (pred_node_count > NODES) ? NODES : pred_node_count;
		active = '0;
		for (int i = 0; i < n; i++) active[i] = 1'b1;
		visited = '0;
		done = 0;
		// first pass: forward walk, record finish order
		for (int i = 0; i < n; i++) begin
			if (!visited[i]) begin
				sp = 0;
				visited[i] = 1'b1;
				stack[sp++] = i;
				while (sp > 0) begin
					top = stack[sp-1];
					row = fwd_rows[top] & ~visited & active;
					nxt = -1;
					for (int b = 0; b < NODES; b++)
						if (nxt < 0 && row[b]) nxt = b;
					if (nxt >= 0) begin
						visited[nxt] = 1'b1;
						stack[sp++] = nxt;
					end else begin
						sp--;
						order[done++] = top;
					end
				end
			end
		end
		// second pass: reverse walks in reverse finish order
		visited = '0;
		tally = 0;
		for (int p = done - 1; p >= 0; p--) begin
			if (!visited[order[p]]) begin
				sp = 0;
				visited[order[p]] = 1'b1;
				stack[sp++] = order[p];
				while (sp > 0) begin
					top = stack[sp-1];
					row = rev_rows[top] & ~visited & active;
					nxt = -1;
					for (int b = 0; b < NODES; b++)
						if (nxt < 0 && row[b]) nxt = b;
					if (nxt >= 0) begin
						visited[nxt] = 1'b1;
						stack[sp++] = nxt;
					end else begin
						sp--;
					end
				end
				tally++;
			end
		end
		for (int i = 0; i < NODES; i++) begin
			fwd_rows[i] = '0;
			rev_rows[i] = '0;
		end
		return tally[CFG_W-1:0];
	endfunction

	// apply one accepted item to the predictor
	task automatic predict_item(input graph_item_t it);
		if (it.command == CMD_EDGE) begin
			fwd_rows[it.edge_from][it.edge_to] = 1'b1;
			rev_rows[it.edge_to][it.edge_from] = 1'b1;
		end else begin
			expected_counts.insert(expected_counts.size(), count_components());
		end
	endtask

	// driver: feeds pending items, idles at random between them
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			command   <= CMD_EDGE;
			edge_from <= '0;
			edge_to   <= '0;
			out_stall <= 1'b0;
		end else begin
			if (!(in_valid && in_stall_q)) begin
				if (pending_items.size() > 0 && !sender_hold
					&& $urandom_range(99) >= send_idle_pct) begin
					command   <= pending_items[0].command;
					edge_from <= pending_items[0].edge_from;
					edge_to   <= pending_items[0].edge_to;
					in_valid  <= 1'b1;
					void'(pending_items.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) in_stall_q <= in_stall;

	// monitor: predicts on accepted inputs, checks accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (in_valid && !in_stall) begin
				predict_item('{command, edge_from, edge_to});
			end
			if (out_valid && !out_stall) begin
				if (expected_counts.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d",
						$realtime, component_count);
					failed = 1'b1;
				end else begin
					if (component_count !== expected_counts[0]) begin
						$display("%0t: component_count mismatch, expected %0d, actual %0d",
							$realtime, expected_counts[0], component_count);
						failed = 1'b1;
					end
					void'(expected_counts.pop_front());
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	task automatic add_edge(input int a, input int b);
		pending_items.insert(pending_items.size(),
			'{CMD_EDGE, a[FIELD_W-1:0], b[FIELD_W-1:0]});
	endtask

	task automatic add_run();
		pending_items.insert(pending_items.size(), '{CMD_RUN, '0, '0});
	endtask

	// wait until every queued item is accepted and every result checked
	task automatic drain();
		while (pending_items.size() > 0 || in_valid || expected_counts.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES / 100) @(posedge clk);
	endtask

	task automatic write_node_count(input int value);
		@(negedge clk);
		node_count <= value[CFG_W-1:0];
		cfg_valid  <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		pred_node_count = value[CFG_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random graph: edges mostly within the limit, one in ten anywhere in the store, then a run
	task automatic random_graph(input int limit, input int edges);
		int a, b;
		for (int e = 0; e < edges; e++) begin
			if ($urandom_range(9) == 0) begin
				a = $urandom_range(63);
				b = $urandom_range(63);
			end else begin
				a = $urandom_range(limit - 1);
				b = $urandom_range(limit - 1);
			end
			add_edge(a, b);
		end
		add_run();
	endtask

	initial begin
		int sizes [6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		node_count = NODE_COUNT_RST;
		sender_hold = 1'b0;
		send_idle_pct = 14;
		recv_idle_pct = 58;
		pred_node_count = NODE_COUNT_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty graph at reset size, full ring, self loop, extremes
		add_run();
		for (int i = 0; i < 64; i++) add_edge(i, (i + 1) % 64);
		add_run();
		add_edge(0, 0);
		add_edge(63, 63);
		add_edge(0, 63);
		add_edge(63, 0);
		add_edge(0, 63);
		add_run();
		drain();
		// one node in use; edges outside it have no effect
		write_node_count(1);
		add_edge(0, 5);
		add_edge(5, 0);
		add_run();
		drain();
		// node count zero and above the maximum
		write_node_count(0);
		add_edge(0, 1);
		add_run();
		drain();
		write_node_count(127);
		add_edge(42, 21);
		add_edge(21, 42);
		add_run();
		drain();

		// random phases, several register settings, three idling profiles
		sizes = '{4, 8, 64, 2, 16, 64};
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				send_idle_pct = 58;
				recv_idle_pct = 14;
			end else if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int s = 0; s < 6; s++) begin
				write_node_count(sizes[s]);
				for (int g = 0; g < 2; g++) begin
					random_graph(sizes[s], $urandom_range(2 * sizes[s] + 5));
				end
				// sender waits for every result once per phase
				if (s == 2) begin
					sender_hold = 1'b1;
					while (expected_counts.size() > 0 || in_valid) @(posedge clk);
					sender_hold = 1'b0;
				end
				drain();
			end
		end

		drain();
		if (!failed) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
